[rtl/chained_hash_table_set_get_top_defines.svh]
// assertion macros shared by the chained hash table modules
`ifndef CHAINED_HASH_TABLE_SET_GET_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_SET_GET_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// shared types, constants and codes of the chained hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

	localparam int unsigned MAX_BUCKETS_DEF = 1024;
	localparam int unsigned MAX_ENTRIES_DEF = 4096;
	localparam logic [35:0] HASH_PRIME = 36'd32212254719;

	// request kinds
	localparam logic REQ_SET = 1'b0;
	localparam logic REQ_GET = 1'b1;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// register indexes
	localparam logic [1:0] REG_MULT   = 2'd0;
	localparam logic [1:0] REG_ADD    = 2'd1;
	localparam logic [1:0] REG_BUCKET = 2'd2;

	// request after hashing, handed from front to back
	typedef struct packed {
		logic        req_type;
		logic [63:0] lookup_key;
		logic [63:0] value_in;
		logic [15:0] bucket;
	} cht_job_t;

endpackage

[rtl/cht_hash.sv]
// ----------------------------------------------------------------------------
// cht_hash
// front part: multiply-add from two 32x32 products, reduction mod the prime
// by folding the upper bits back in, then sequential reduction mod the bucket
// count by restoring shift-subtract, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_hash #(
	parameter int unsigned MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
	localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_req_type,
	input  logic [63:0]           in_key,
	input  logic [63:0]           in_value,
	input  logic [31:0]           hash_mult,
	input  logic [31:0]           hash_add,
	input  logic [10:0]           bucket_count,
	output logic                  job_valid,
	input  logic                  job_ready,
	output cht_pkg::cht_job_t     job
);

	typedef enum logic [5:0] {
		H_IDLE = 6'b000001,
		H_MUL  = 6'b000010,
		H_MUL2 = 6'b000100,
		H_MODP = 6'b001000,
		H_MODN = 6'b010000,
		H_OUT  = 6'b100000
	} h_state_t;

	h_state_t    state_q;
	logic        req_q;
	logic [63:0] key_q;
	logic [63:0] val_q;
	logic [63:0] h_q;
	logic [16:0] rem_q;
	logic [6:0]  cnt_q;
	logic [16:0] n_q;
	logic [15:0] bucket_q;
	logic [17:0] rem_sh;
	logic [16:0] rem_sub;
	logic [63:0] prod_lo;
	logic [31:0] prod_hi;
	logic [63:0] fold;
	logic        fold_done;
	logic [16:0] n_eff;

	// effective bucket count, clamped to 1..MAX_BUCKETS
	always_comb begin
		if (bucket_count == 11'd0) begin
			n_eff = 17'd1;
		end else if ({6'd0, bucket_count} > 17'(MAX_BUCKETS)) begin
			n_eff = 17'(MAX_BUCKETS);
		end else begin
			n_eff = {6'd0, bucket_count};
		end
	end

	// 32x32 partial products of the multiply-add
	assign prod_lo = {32'd0, hash_mult} * {32'd0, key_q[31:0]};
	assign prod_hi = hash_mult * key_q[63:32];

	// 2^35 = 2^31 + 1 mod p, so the bits above bit 35 fold back in
	assign fold_done = (h_q[63:35] == 29'd0);
	assign fold      = {4'd0, h_q[63:35], 31'd0} + {35'd0, h_q[63:35]} + {29'd0, h_q[34:0]};

	// one restoring step of the running remainder mod n
	always_comb begin
		rem_sh  = {rem_q, h_q[35]};
		rem_sub = (rem_sh >= {1'b0, n_q}) ? 17'(rem_sh - {1'b0, n_q}) : rem_sh[16:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (in_valid) begin
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					state_q <= H_MUL2;
				end
				H_MUL2: begin
					state_q <= H_MODP;
				end
				H_MODP: begin
					if (fold_done) begin
						state_q <= H_MODN;
						cnt_q   <= 7'd35;
					end
				end
				H_MODN: begin
					// remainder mod p sits in h_q[35:0], shifted in msb first
					if (cnt_q == 7'd0) begin
						state_q <= H_OUT;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				H_OUT: begin
					if (job_ready) begin
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				req_q <= in_req_type;
				key_q <= in_key;
				val_q <= in_value;
				n_q   <= n_eff;
			end
			H_MUL: begin
				h_q <= prod_lo + {32'd0, hash_add};
			end
			H_MUL2: begin
				h_q   <= h_q + {prod_hi, 32'd0};
				rem_q <= '0;
			end
			H_MODP: begin
				// below 2^35 one compare-subtract finishes the reduction
				if (!fold_done) begin
					h_q <= fold;
				end else if (h_q >= 64'(cht_pkg::HASH_PRIME)) begin
					h_q <= h_q - 64'(cht_pkg::HASH_PRIME);
				end
			end
			H_MODN: begin
				rem_q <= rem_sub;
				h_q   <= {h_q[62:0], 1'b0};
				if (cnt_q == 7'd0) begin
					bucket_q <= rem_sub[15:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready        = (state_q == H_IDLE);
	assign job_valid       = (state_q == H_OUT);
	assign job.req_type    = req_q;
	assign job.lookup_key  = key_q;
	assign job.value_in    = val_q;
	assign job.bucket      = {{(16 - BW){1'b0}}, bucket_q[BW-1:0]};

	`include "chained_hash_table_set_get_top_defines.svh"

	`CHT_ASSERT_IMP(a_bucket_range, clk, arst_n, job_valid, ({1'b0, job.bucket} < n_q), "bucket beyond count")
	`CHT_ASSERT_NEXT(a_take_one, clk, arst_n, in_valid && in_ready, state_q == H_MUL, "request not taken")
	`CHT_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")

endmodule

[rtl/cht_queue.sv]
// ----------------------------------------------------------------------------
// cht_queue
// two-entry queue of hashed requests between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  cht_pkg::cht_job_t wr_job,
	output logic              rd_valid,
	input  logic              rd_ready,
	output cht_pkg::cht_job_t rd_job
);

	cht_pkg::cht_job_t mem_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic              pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_job   = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	`include "chained_hash_table_set_get_top_defines.svh"

	`CHT_ASSERT_IMP(a_no_over, clk, arst_n, 1'b1, cnt_q <= 2'd2, "queue level out of range")
	`CHT_ASSERT_NEXT(a_level, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "push lost")
	`CHT_ASSERT_IMP(a_ptr, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2, wp_q == rp_q, "pointer mismatch")

endmodule

[rtl/cht_engine.sv]
// ----------------------------------------------------------------------------
// cht_engine
// back part: walks the bucket chain through the entry pool, then updates,
// inserts or reports, and holds the result in an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_engine #(
	parameter int unsigned MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
	parameter int unsigned MAX_ENTRIES = cht_pkg::MAX_ENTRIES_DEF,
	localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
	localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int unsigned LW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  cht_pkg::cht_job_t job,
	output logic              busy,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [2:0]        res_status,
	output logic [63:0]       res_value,
	output logic [12:0]       res_total
);

	typedef enum logic [6:0] {
		E_IDLE  = 7'b0000001,
		E_CLEAR = 7'b0000010,
		E_HEAD  = 7'b0000100,
		E_WAIT  = 7'b0001000,
		E_CMP   = 7'b0010000,
		E_DONE  = 7'b0100000,
		E_OUT   = 7'b1000000
	} e_state_t;

	// bucket heads: memory with clearing pass after reset
	logic [LW-1:0] head_mem [MAX_BUCKETS];
	logic [63:0]   key_mem  [MAX_ENTRIES];
	logic [63:0]   val_mem  [MAX_ENTRIES];
	logic [LW-1:0] link_mem [MAX_ENTRIES];

	e_state_t      state_q;
	logic [BW:0]   clr_q;
	logic [LW-1:0] count_q;
	cht_pkg::cht_job_t job_q;
	logic [LW-1:0] link_q;
	logic          link_walk_q;
	logic [LW-1:0] head_rd_q;
	logic [63:0]   ekey_rd_q;
	logic [63:0]   eval_rd_q;
	logic [LW-1:0] elink_rd_q;
	logic [2:0]    st_q;
	logic [63:0]   vo_q;
	logic [EW-1:0] eidx;
	logic [BW-1:0] bidx;
	logic          link_ok;

	assign bidx    = job_q.bucket[BW-1:0];
	assign eidx    = EW'(link_q - LW'(1));
	assign link_ok = (link_q != '0) && (link_q <= count_q);

	// head memory port
	always_ff @(posedge clk) begin
		if (state_q == E_CLEAR) begin
			head_mem[clr_q[BW-1:0]] <= '0;
		end else if (state_q == E_DONE && job_q.req_type == cht_pkg::REQ_SET
			&& !link_ok && count_q < LW'(MAX_ENTRIES)) begin
			head_mem[bidx] <= count_q + LW'(1);
		end
		head_rd_q <= head_mem[bidx];
	end

	// entry memory ports
	always_ff @(posedge clk) begin
		if (state_q == E_DONE && job_q.req_type == cht_pkg::REQ_SET) begin
			if (link_ok) begin
				val_mem[eidx] <= job_q.value_in;
			end else if (count_q < LW'(MAX_ENTRIES)) begin
				key_mem[EW'(count_q)]  <= job_q.lookup_key;
				val_mem[EW'(count_q)]  <= job_q.value_in;
				link_mem[EW'(count_q)] <= head_rd_q;
			end
		end
		ekey_rd_q  <= key_mem[eidx];
		eval_rd_q  <= val_mem[eidx];
		elink_rd_q <= link_mem[eidx];
	end

	// chain walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				E_CLEAR: begin
					clr_q <= clr_q + (BW + 1)'(1);
					if (clr_q == (BW + 1)'(MAX_BUCKETS - 1)) begin
						state_q <= E_IDLE;
					end
				end
				E_IDLE: begin
					if (job_valid) begin
						state_q <= E_HEAD;
					end
				end
				E_HEAD: state_q <= E_WAIT;
				// first visit loads the head link, later visits wait on the read
				E_WAIT: state_q <= link_walk_q ? E_CMP : E_WAIT;
				E_CMP: begin
					if (!link_ok || ekey_rd_q == job_q.lookup_key) begin
						state_q <= E_DONE;
					end else begin
						state_q <= E_WAIT;
					end
				end
				E_DONE: begin
					state_q <= E_OUT;
					if (job_q.req_type == cht_pkg::REQ_SET && !link_ok
						&& count_q < LW'(MAX_ENTRIES)) begin
						count_q <= count_q + LW'(1);
					end
				end
				E_OUT: begin
					if (res_ready) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// job capture, link following and result
	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				job_q <= job;
			end
			default: begin
			end
		endcase
		if (state_q == E_HEAD) begin
			link_q <= '0;
		end else if (state_q == E_WAIT) begin
			if (link_q == '0 && !link_walk_q) begin
				link_q <= head_rd_q;
			end
		end else if (state_q == E_CMP && link_ok && ekey_rd_q != job_q.lookup_key) begin
			link_q <= elink_rd_q;
		end
		if (state_q == E_DONE) begin
			vo_q <= (job_q.req_type == cht_pkg::REQ_GET && link_ok) ? eval_rd_q : '0;
			if (job_q.req_type == cht_pkg::REQ_GET) begin
				st_q <= link_ok ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
			end else if (link_ok) begin
				st_q <= cht_pkg::ST_UPDATED;
			end else if (count_q < LW'(MAX_ENTRIES)) begin
				st_q <= cht_pkg::ST_INSERTED;
			end else begin
				st_q <= cht_pkg::ST_FULL;
			end
		end
	end

	// marks that link_q already holds a walked link in this request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_walk_q <= 1'b0;
		end else if (state_q == E_HEAD) begin
			link_walk_q <= 1'b0;
		end else if (state_q == E_WAIT) begin
			link_walk_q <= 1'b1;
		end
	end

	assign job_ready  = (state_q == E_IDLE);
	assign busy       = !(state_q == E_IDLE || state_q == E_CLEAR);
	assign res_valid  = (state_q == E_OUT);
	assign res_status = st_q;
	assign res_value  = vo_q;
	assign res_total  = 13'(count_q);

	`include "chained_hash_table_set_get_top_defines.svh"

	`CHT_ASSERT_IMP(a_count, clk, arst_n, 1'b1, count_q <= LW'(MAX_ENTRIES), "count beyond pool")
	`CHT_ASSERT_IMP(a_zero_val, clk, arst_n, res_valid && res_status != cht_pkg::ST_FOUND, res_value == 64'd0, "value on non-found result")
	`CHT_ASSERT_NEXT(a_grow, clk, arst_n, res_valid && res_ready && res_status == cht_pkg::ST_INSERTED, count_q == $past(count_q), "count moved after insert")

endmodule

[rtl/chained_hash_table_set_get_top.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_set_get_top
// key-value store with separate chaining and a universal hash
// ----------------------------------------------------------------------------
// Requests enter on the s_axis group: tuser carries req_type, tdata carries
// lookup_key (bits 63:0) and value_in (bits 127:64). Every request yields one
// result on m_axis: tdata holds status, value_out and entry_total.
// The front hashes a request with a multiply-add from two 32x32 products
// (states H_MUL, H_MUL2), a reduction mod the prime (upper bits folded back
// in, then one compare-subtract) and a 36-step reduction mod the bucket
// count, one bit per cycle. The back visits each chain entry with a
// registered memory read, then a key compare (an empty chain counts as one
// visit), plus the bucket-head read and the final update or report. A
// two-deep queue lets the front hash the next request while the back walks;
// the front takes a new request only once it has handed the last one on.
// Sustained rate is set by the hash unit for short chains and by the chain
// walk for long ones. After reset the back clears the bucket-head memory,
// one bucket a cycle; requests wait in the queue meanwhile. The result stays
// in the output register while m_axis_tready is low, and the back stalls
// until it is taken. Registers on the APB port: hash_mult at 0x0,
// hash_add at 0x4, bucket_count at 0x8; write them only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_table_set_get_top #(
	parameter int unsigned MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
	parameter int unsigned MAX_ENTRIES = cht_pkg::MAX_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// lookup_key [63:0], value_in [127:64]
	input  logic [127:0] s_axis_tdata,
	// req_type [0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status [2:0], value_out [66:3], entry_total [79:67]
	output logic [79:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [31:0] mult_q;
	logic [31:0] add_q;
	logic [10:0] bcnt_q;
	logic        wr_en;
	logic        hjob_valid;
	logic        hjob_ready;
	cht_pkg::cht_job_t hjob;
	logic        qjob_valid;
	logic        qjob_ready;
	cht_pkg::cht_job_t qjob;
	logic        eng_busy;
	logic [2:0]  st;
	logic [63:0] vo;
	logic [12:0] tot;

	// register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= 32'd1;
			add_q  <= 32'd0;
			bcnt_q <= 11'd1024;
		end else if (wr_en) begin
			case (paddr[3:2])
				cht_pkg::REG_MULT:   mult_q <= pwdata;
				cht_pkg::REG_ADD:    add_q  <= pwdata;
				cht_pkg::REG_BUCKET: bcnt_q <= pwdata[10:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cht_pkg::REG_MULT:   prdata = mult_q;
			cht_pkg::REG_ADD:    prdata = add_q;
			cht_pkg::REG_BUCKET: prdata = {21'd0, bcnt_q};
			default:             prdata = 32'd0;
		endcase
	end

	cht_hash #(.MAX_BUCKETS(MAX_BUCKETS)) u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_req_type  (s_axis_tuser),
		.in_key       (s_axis_tdata[63:0]),
		.in_value     (s_axis_tdata[127:64]),
		.hash_mult    (mult_q),
		.hash_add     (add_q),
		.bucket_count (bcnt_q),
		.job_valid    (hjob_valid),
		.job_ready    (hjob_ready),
		.job          (hjob)
	);

	cht_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (hjob_valid),
		.wr_ready (hjob_ready),
		.wr_job   (hjob),
		.rd_valid (qjob_valid),
		.rd_ready (qjob_ready),
		.rd_job   (qjob)
	);

	cht_engine #(.MAX_BUCKETS(MAX_BUCKETS), .MAX_ENTRIES(MAX_ENTRIES)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (qjob_valid),
		.job_ready  (qjob_ready),
		.job        (qjob),
		.busy       (eng_busy),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_status (st),
		.res_value  (vo),
		.res_total  (tot)
	);

	assign m_axis_tdata = {tot, vo, st};

	`include "chained_hash_table_set_get_top_defines.svh"

	`CHT_ASSERT_IMP(a_res_busy, clk, arst_n, m_axis_tvalid, eng_busy, "result without work")
	`CHT_ASSERT_IMP(a_status_ok, clk, arst_n, m_axis_tvalid, st <= cht_pkg::ST_FULL, "bad status code")
	`CHT_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")

endmodule
